// ----- sv/ipu_pkg.sv -----
// Shared types and constants for the indexed pixel unpacker.
// No dependencies; ipu_expand, ipu_outbuf and indexed_pixel_unpacker refer to this package.
`default_nettype none
package ipu_pkg;

  // Palette storage
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
  localparam int PAL_W     = 24;

  // Row geometry: the width register is 9 bits, the column counter spans MAX_WIDTH
  localparam int MAX_WIDTH = 256;
  localparam int RW_W      = 9;
  localparam int COL_W     = $clog2(MAX_WIDTH + 1);
  localparam int EW        = (COL_W > RW_W) ? COL_W : RW_W;

  // Output buffer
  localparam int OB_DEPTH  = 4;
  localparam int OB_AW     = $clog2(OB_DEPTH);

  localparam int CNT_W     = 4;

  typedef enum logic [2:0] {
    DEPTH_1BPP  = 3'd0,
    DEPTH_4BPP  = 3'd1,
    DEPTH_8BPP  = 3'd2,
    DEPTH_24BPP = 3'd3,
    DEPTH_32BPP = 3'd4
  } depth_e;

  typedef enum logic [1:0] {
    REG_DEPTH_MODE = 2'd0,
    REG_ROW_WIDTH  = 2'd1
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // One pixel leaving the expander toward the palette read / output buffer
  typedef struct packed {
    logic  valid;
    logic  use_ram;
    logic  row_end;
    rgba_t pix;
  } issue_t;

  typedef struct packed {
    logic  row_end;
    rgba_t pix;
  } obuf_entry_t;

endpackage
`default_nettype wire

// ----- sv/ipu_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Read-first: a read and write of the same address in one cycle returns old data.
`default_nettype none
module ipu_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- sv/ipu_expand.sv -----
// Pixel expander: config registers, byte shifter, BGR(A) gather and column counter.
// Issues one pixel per cycle (palette lookup or direct color) while the output side has room. Uses ipu_pkg.
`default_nettype none
module ipu_expand (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [ipu_pkg::RW_W-1:0]     cfg_wdata_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         kind_i,
  input  wire logic [7:0]                   data_byte_i,
  input  wire logic                         room_i,
  output logic                              in_ready_o,
  output ipu_pkg::issue_t                   issue_o,
  output logic [ipu_pkg::PAL_AW-1:0]        raddr_o
);

  logic [2:0]                   depth_q, depth_d;
  logic [ipu_pkg::RW_W-1:0]     width_q, width_d;
  logic [ipu_pkg::EW-1:0]       col_q, col_d;
  logic [1:0]                   phase_q, phase_d;
  logic [23:0]                  gather_q, gather_d;
  logic [ipu_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [7:0]                   sh_q, sh_d;
  logic                         dir_q, dir_d;
  ipu_pkg::rgba_t               pix_q, pix_d;

  logic [ipu_pkg::EW-1:0] eff_w;
  logic [ipu_pkg::EW-1:0] col_inc;
  logic                   last;
  logic                   issue;
  logic                   byte_fire;
  logic [7:0]             idx;
  logic                   in_range;
  logic                   cfg_hit;
  logic [1:0]             need;

  // effective width: zero acts as 1, clamp at MAX_WIDTH
  always_comb begin
    if (width_q == '0) begin
      eff_w = ipu_pkg::EW'(1);
    end else if (ipu_pkg::EW'(width_q) > ipu_pkg::EW'(ipu_pkg::MAX_WIDTH)) begin
      eff_w = ipu_pkg::EW'(ipu_pkg::MAX_WIDTH);
    end else begin
      eff_w = ipu_pkg::EW'(width_q);
    end
  end

  assign col_inc = ipu_pkg::EW'(col_q + 1'b1);
  assign last    = (col_inc >= eff_w);
  assign issue   = (cnt_q != '0) && room_i;

  always_comb begin
    case (depth_q)
      ipu_pkg::DEPTH_1BPP: idx = {7'd0, sh_q[7]};
      ipu_pkg::DEPTH_4BPP: idx = {4'd0, sh_q[7:4]};
      default:             idx = sh_q;
    endcase
  end

  assign in_range = ({1'b0, idx} < 9'(ipu_pkg::PAL_DEPTH));
  assign raddr_o  = idx[ipu_pkg::PAL_AW-1:0];

  always_comb begin
    issue_o.valid   = issue;
    issue_o.use_ram = !dir_q && in_range;
    issue_o.row_end = last;
    // out-of-range index reads as black
    issue_o.pix     = dir_q ? pix_q :
                      ipu_pkg::rgba_t'{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'hFF};
  end

  // ready while nothing is pending, or in the cycle the last pending pixel (or a row's last) issues
  assign in_ready_o = (cnt_q == '0) ||
                      (issue && ((cnt_q == ipu_pkg::CNT_W'(1)) || last));
  assign byte_fire  = in_valid_i && in_ready_o && kind_i;
  assign cfg_hit    = cfg_we_i && ((cfg_idx_i == ipu_pkg::REG_DEPTH_MODE) ||
                                   (cfg_idx_i == ipu_pkg::REG_ROW_WIDTH));
  assign need       = (depth_q == ipu_pkg::DEPTH_24BPP) ? 2'd2 : 2'd3;

  always_comb begin
    depth_d  = depth_q;
    width_d  = width_q;
    col_d    = col_q;
    phase_d  = phase_q;
    gather_d = gather_q;
    cnt_d    = cnt_q;
    sh_d     = sh_q;
    dir_d    = dir_q;
    pix_d    = pix_q;

    if (issue) begin
      col_d = last ? '0 : col_inc;
      // a row ending inside a 1/4 bpp byte drops the rest of the byte
      if (last && ((depth_q == ipu_pkg::DEPTH_1BPP) || (depth_q == ipu_pkg::DEPTH_4BPP))) begin
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
      if (depth_q == ipu_pkg::DEPTH_1BPP) begin
        sh_d = {sh_q[6:0], 1'b0};
      end else if (depth_q == ipu_pkg::DEPTH_4BPP) begin
        sh_d = {sh_q[3:0], 4'd0};
      end
    end

    if (byte_fire) begin
      sh_d  = data_byte_i;
      dir_d = 1'b0;
      case (depth_q)
        ipu_pkg::DEPTH_1BPP: cnt_d = ipu_pkg::CNT_W'(8);
        ipu_pkg::DEPTH_4BPP: cnt_d = ipu_pkg::CNT_W'(2);
        ipu_pkg::DEPTH_8BPP: cnt_d = ipu_pkg::CNT_W'(1);
        ipu_pkg::DEPTH_24BPP, ipu_pkg::DEPTH_32BPP: begin
          if (phase_q >= need) begin
            dir_d       = 1'b1;
            cnt_d       = ipu_pkg::CNT_W'(1);
            pix_d.blue  = gather_q[7:0];
            pix_d.green = gather_q[15:8];
            pix_d.red   = (depth_q == ipu_pkg::DEPTH_24BPP) ? data_byte_i : gather_q[23:16];
            pix_d.alpha = (depth_q == ipu_pkg::DEPTH_32BPP) ? data_byte_i : 8'hFF;
            phase_d     = 2'd0;
            gather_d    = '0;
          end else begin
            cnt_d = '0;
            case (phase_q)
              2'd0:    gather_d[7:0]   = data_byte_i;
              2'd1:    gather_d[15:8]  = data_byte_i;
              default: gather_d[23:16] = data_byte_i;
            endcase
            phase_d = phase_q + 1'b1;
          end
        end
        default: cnt_d = '0;  // undefined depth: byte ignored
      endcase
    end

    if (cfg_hit) begin
      if (cfg_idx_i == ipu_pkg::REG_DEPTH_MODE) begin
        depth_d = cfg_wdata_i[2:0];
      end else begin
        width_d = cfg_wdata_i;
      end
      col_d    = '0;
      phase_d  = '0;
      gather_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= ipu_pkg::DEPTH_8BPP;
      width_q  <= ipu_pkg::RW_W'(32);
      col_q    <= '0;
      phase_q  <= '0;
      gather_q <= '0;
      cnt_q    <= '0;
    end else begin
      depth_q  <= depth_d;
      width_q  <= width_d;
      col_q    <= col_d;
      phase_q  <= phase_d;
      gather_q <= gather_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    dir_q <= dir_d;
    pix_q <= pix_d;
  end

endmodule
`default_nettype wire

// ----- sv/ipu_outbuf.sv -----
// Read-return stage and 4-entry output queue; merges palette data or direct pixels.
// Reports room to the expander from registered occupancy only. Uses ipu_pkg.
`default_nettype none
module ipu_outbuf (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire ipu_pkg::issue_t             issue_i,
  input  wire logic [ipu_pkg::PAL_W-1:0]   rdata_i,
  output logic                             room_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output ipu_pkg::obuf_entry_t             out_o
);

  logic                     rv_q;
  ipu_pkg::issue_t          rinfo_q;
  ipu_pkg::obuf_entry_t     fifo_q [ipu_pkg::OB_DEPTH];
  logic [ipu_pkg::OB_AW-1:0] wp_q, rp_q;
  logic [ipu_pkg::OB_AW:0]  cnt_q, cnt_d;
  ipu_pkg::obuf_entry_t     push_data;
  logic                     pop;

  always_comb begin
    push_data.row_end = rinfo_q.row_end;
    if (rinfo_q.use_ram) begin
      push_data.pix = '{red: rdata_i[23:16], green: rdata_i[15:8],
                        blue: rdata_i[7:0], alpha: 8'hFF};
    end else begin
      push_data.pix = rinfo_q.pix;
    end
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = fifo_q[rp_q];
  // queue plus the read in flight must leave a slot for one more issue
  assign room_o      = ((cnt_q + (ipu_pkg::OB_AW+1)'(rv_q)) <
                        (ipu_pkg::OB_AW+1)'(ipu_pkg::OB_DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (rv_q && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!rv_q && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q  <= 1'b0;
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      rv_q  <= issue_i.valid;
      cnt_q <= cnt_d;
      if (rv_q) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rinfo_q <= issue_i;
    if (rv_q) begin
      fifo_q[wp_q] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/indexed_pixel_unpacker.sv -----
// Path: an accepted byte is held in the expander, its pixel is registered by the palette read, then queued.
// Throughput: one pixel per cycle while the output queue has room; a 4 bpp byte yields two pixels, a 1 bpp byte
// up to eight, set by the single palette read port (one lookup per cycle). A palette load is written as accepted.
// Reset (async, low): depth 8 bpp, width 32, column/gather cleared, queue empty.
// The palette RAM has no reset and no clearing pass; entries are defined once loaded.
// Depends on ipu_pkg, ipu_ram, ipu_expand, ipu_outbuf.
`default_nettype none
module indexed_pixel_unpacker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration writes
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [ipu_pkg::RW_W-1:0]  cfg_wdata_i,
  // input transfer
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      kind_i,
  input  wire logic [7:0]                data_byte_i,
  input  wire logic [7:0]                entry_index_i,
  input  wire logic [7:0]                entry_first_i,
  input  wire logic [7:0]                entry_second_i,
  input  wire logic [7:0]                entry_third_i,
  // output transfer
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o,
  output logic [7:0]                     alpha_o,
  output logic                           row_end_o
);

  ipu_pkg::issue_t            issue;
  ipu_pkg::obuf_entry_t       head;
  logic [ipu_pkg::PAL_AW-1:0] raddr;
  logic [ipu_pkg::PAL_W-1:0]  rdata;
  logic                       room;
  logic                       pal_we;

  // Palette loads share the input handshake. in_ready is only high when no
  // lookup of an earlier byte remains after this cycle, and the RAM is
  // read-first, so a load never overtakes a lookup that precedes it.
  // Slots at or above the palette depth are dropped.
  assign pal_we = in_valid_i && in_ready_o && !kind_i &&
                  ({1'b0, entry_index_i} < 9'(ipu_pkg::PAL_DEPTH));

  ipu_ram #(
    .Width (ipu_pkg::PAL_W),
    .Depth (ipu_pkg::PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (entry_index_i[ipu_pkg::PAL_AW-1:0]),
    .wdata_i ({entry_third_i, entry_second_i, entry_first_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Expander: one pixel issued per cycle when the output side has room.
  ipu_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .room_i      (room),
    .in_ready_o  (in_ready_o),
    .issue_o     (issue),
    .raddr_o     (raddr)
  );

  // Read return plus output queue; decouples out_ready from in_ready.
  ipu_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .rdata_i     (rdata),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  assign red_o     = head.pix.red;
  assign green_o   = head.pix.green;
  assign blue_o    = head.pix.blue;
  assign alpha_o   = head.pix.alpha;
  assign row_end_o = head.row_end;

endmodule
`default_nettype wire

// ----- sv/ipu_checker.sv -----
// Port-level checks for indexed_pixel_unpacker, attached by bind.
// Sees only the top-level ports; no package dependency.
`default_nettype none
module ipu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] red_o,
  input wire logic [7:0] green_o,
  input wire logic [7:0] blue_o,
  input wire logic [7:0] alpha_o,
  input wire logic       row_end_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(green_o) &&
      $stable(blue_o) && $stable(alpha_o) && $stable(row_end_o))
    else $error("stalled output changed");

  // in reset: empty queue, input open
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o && in_ready_o)
    else $error("reset state wrong");

  // input side closes only after a transfer, or stays closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(in_valid_i && in_ready_o) || $past(!in_ready_o))
    else $error("in_ready dropped without a transfer");

  // a result appears only after an earlier input transfer or a pending lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 3) || $past(!in_ready_o, 2) ||
      $past(!in_ready_o, 3))
    else $error("result without input");

endmodule

bind indexed_pixel_unpacker ipu_checker u_ipu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o),
  .alpha_o     (alpha_o),
  .row_end_o   (row_end_o)
);
`default_nettype wire
